>>> rtl/cis_pkg.sv
// ----------------------------------------------------------------------------
// cis_pkg
// Shared types, register indexes and the ASCII case-folding function for the
// case-insensitive substring search block.
// ----------------------------------------------------------------------------
package cis_pkg;

  localparam int PAT_BYTES = 16;
  localparam int LEN_W     = 5;
  localparam int OFS_W     = 16;
  localparam int REG_W     = 64;
  localparam int ADDR_W    = 5;

  // Register indexes (byte address = 8 * index).
  localparam logic [1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [1:0] REG_PAT_LEN  = 2'd2;

  localparam logic [LEN_W-1:0] PAT_LEN_RESET = 5'd1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [8*PAT_BYTES-1:0] pattern;
    logic [LEN_W-1:0]       pat_len;
  } cfg_t;

  typedef struct packed {
    logic             found;
    logic [OFS_W-1:0] offset;
    logic             overflow;
  } result_t;

  function automatic byte_t fold(input byte_t b);
    byte_t r;
    r = b;
    if (b >= 8'h61 && b <= 8'h7A) begin
      r = b - 8'h20;
    end
    return r;
  endfunction

endpackage

>>> rtl/cis_cfg.sv
// ----------------------------------------------------------------------------
// cis_cfg
// APB-style register file holding the search pattern and its length.
// ----------------------------------------------------------------------------
module cis_cfg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [cis_pkg::ADDR_W-1:0] paddr,
  input  logic [cis_pkg::REG_W-1:0]  pwdata,
  output logic [cis_pkg::REG_W-1:0]  prdata,
  output logic                  pready,
  output cis_pkg::cfg_t         cfg
);
  import cis_pkg::*;

  logic [REG_W-1:0] pat_low_r;
  logic [REG_W-1:0] pat_high_r;
  logic [LEN_W-1:0] pat_len_r;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= PAT_LEN_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PAT_LOW:  pat_low_r  <= pwdata;
        REG_PAT_HIGH: pat_high_r <= pwdata;
        REG_PAT_LEN:  pat_len_r  <= pwdata[LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PAT_LOW:  prdata = pat_low_r;
      REG_PAT_HIGH: prdata = pat_high_r;
      REG_PAT_LEN:  prdata = {{(REG_W-LEN_W){1'b0}}, pat_len_r};
      default:      prdata = '0;
    endcase
  end

  assign cfg.pattern = {pat_high_r, pat_low_r};
  assign cfg.pat_len = pat_len_r;

endmodule

>>> rtl/cis_match.sv
// ----------------------------------------------------------------------------
// cis_match
// Folded byte window, position counter and parallel pattern compare. Keeps
// the per-string match record and forms the result on the final byte.
// ----------------------------------------------------------------------------
module cis_match #(
  parameter int              PATTERN_MAX = 16,
  parameter longint unsigned STRING_MAX  = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  cis_pkg::byte_t    text_byte,
  input  logic              last_byte,
  input  cis_pkg::cfg_t     cfg,
  output cis_pkg::result_t  res
);
  import cis_pkg::*;

  localparam int CNT_W  = $clog2(STRING_MAX + 1);
  localparam int WIDE_W = (CNT_W > OFS_W) ? CNT_W : OFS_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(STRING_MAX);

  byte_t            win_r   [PATTERN_MAX];
  byte_t            win_nxt [PATTERN_MAX];
  byte_t            pat     [PATTERN_MAX];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             match_r, match_nxt;
  logic [OFS_W-1:0] ofs_r, ofs_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LEN_W-1:0] len_use;
  logic [PATTERN_MAX-1:0] hit_len;
  logic             hit_sel;
  logic             hit;
  logic             full;
  logic [WIDE_W-1:0] new_ofs;

  always_comb begin
    len_use = cfg.pat_len;
    if (len_use == '0) begin
      len_use = LEN_W'(1);
    end else if (len_use > LEN_W'(PATTERN_MAX)) begin
      len_use = LEN_W'(PATTERN_MAX);
    end
  end

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      pat[k] = fold(cfg.pattern[8*k +: 8]);
    end
  end

  assign full = (cnt_r >= CNT_MAX);

  // Newest byte enters at entry 0; a saturated string leaves the window alone.
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      win_nxt[j] = win_r[j];
    end
    if (!full) begin
      win_nxt[0] = fold(text_byte);
      for (int j = 1; j < PATTERN_MAX; j++) begin
        win_nxt[j] = win_r[j-1];
      end
    end
  end

  // One compare set per candidate length; the used length picks one.
  always_comb begin
    for (int l = 0; l < PATTERN_MAX; l++) begin
      hit_len[l] = 1'b1;
      for (int k = 0; k <= l; k++) begin
        if (win_nxt[l-k] != pat[k]) begin
          hit_len[l] = 1'b0;
        end
      end
    end
    hit_sel = 1'b0;
    for (int l = 0; l < PATTERN_MAX; l++) begin
      if (len_use == LEN_W'(l + 1)) begin
        hit_sel = hit_len[l];
      end
    end
  end

  assign cnt_nxt = full ? cnt_r : cnt_r + CNT_W'(1);
  assign hit     = !full && hit_sel && (WIDE_W'(cnt_nxt) >= WIDE_W'(len_use));
  assign new_ofs = WIDE_W'(cnt_nxt) - WIDE_W'(len_use);

  assign match_nxt = match_r | hit;
  assign ofs_nxt   = (hit && !match_r) ? new_ofs[OFS_W-1:0] : ofs_r;
  assign ovf_nxt   = ovf_r | full;

  assign res.found    = match_nxt;
  assign res.offset   = match_nxt ? ofs_nxt : '0;
  assign res.overflow = ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      match_r <= 1'b0;
      ofs_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (step) begin
      if (last_byte) begin
        cnt_r   <= '0;
        match_r <= 1'b0;
        ofs_r   <= '0;
        ovf_r   <= 1'b0;
      end else begin
        cnt_r   <= cnt_nxt;
        match_r <= match_nxt;
        ofs_r   <= ofs_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  // Window entries older than the string are never compared, so no clear.
  always_ff @(posedge clk) begin
    if (step) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        win_r[j] <= win_nxt[j];
      end
    end
  end

endmodule

>>> rtl/case_insensitive_substring_search_top.sv
// ----------------------------------------------------------------------------
// case_insensitive_substring_search_top
// Streams a string one byte per word and reports whether a case-folded
// pattern occurs in it, and where it first starts.
//
// The input channel (in_valid/in_ready) carries one text byte per word, with
// in_last_byte set on the final byte of each string. The output channel
// (out_valid/out_ready) carries one result word per string: found, the low
// 16 bits of the first match offset, and an overflow flag for strings longer
// than STRING_MAX bytes. Pattern and length (APB-style, byte addresses 0, 8,
// 16) must be written only with no string in flight; the block does not check.
//
// Throughput is one byte per cycle while no final byte waits on a stalled
// output register: a byte is registered, then compared against all pattern
// lengths in parallel. The result word is registered once the final byte
// has been compared. When the receiver stalls, the result holds in the output
// register; further bytes of the next string are still taken until another
// final byte waits on it. Reset clears the pattern to zero with length one
// and drops any string in progress.
// ----------------------------------------------------------------------------
module case_insensitive_substring_search_top #(
  parameter int              PATTERN_MAX = 16,
  parameter longint unsigned STRING_MAX  = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_text_byte,
  input  logic                               in_last_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic [cis_pkg::OFS_W-1:0]          out_match_offset,
  output logic                               out_length_overflow,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cis_pkg::ADDR_W-1:0]         paddr,
  input  logic [cis_pkg::REG_W-1:0]          pwdata,
  output logic [cis_pkg::REG_W-1:0]          prdata,
  output logic                               pready
);
  import cis_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_r;
  byte_t   byte_r;
  logic    last_r;
  logic    s1_valid_r;
  logic    out_valid_r;
  logic    step;
  logic    accept;

  cis_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cis_match #(
    .PATTERN_MAX (PATTERN_MAX),
    .STRING_MAX  (STRING_MAX)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .text_byte (byte_r),
    .last_byte (last_r),
    .cfg       (cfg),
    .res       (res)
  );

  // A final byte moves on only when the output register is free or draining.
  assign step     = s1_valid_r && (!last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_text_byte;
      last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && last_r) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_found           = out_r.found;
  assign out_match_offset    = out_r.offset;
  assign out_length_overflow = out_r.overflow;

endmodule
